// ===== hw/rtl/vrte_pkg.sv =====
// Shared constants, operation codes and helpers for the virtual route table engine.
package vrte_pkg;

	localparam int ENTRIES_DEF  = 64;
	localparam int VID_BITS_DEF = 16;
	localparam int PATH_W       = 32;
	localparam int STATUS_W     = 7;
	localparam int COUNT_W      = 7;
	localparam int RIDX_W       = 6;
	localparam int KIND_W       = 4;
	localparam int AVAIL_W      = 2;

	typedef enum logic [KIND_W-1:0] {
		K_CLEAR     = 4'd0,
		K_INSERT    = 4'd1,
		K_REMOVE    = 4'd2,
		K_DROP_END  = 4'd3,
		K_ADD_END   = 4'd4,
		K_QUERY_END = 4'd5,
		K_PICK      = 4'd6,
		K_HOP       = 4'd7,
		K_VSET      = 4'd8,
		K_SET_HOP   = 4'd9,
		K_DISMANTLE = 4'd10
	} kind_t;

	localparam logic [AVAIL_W-1:0] AV_BLOCKED = 2'd0;
	localparam logic [AVAIL_W-1:0] AV_OK      = 2'd1;
	localparam logic [AVAIL_W-1:0] AV_TEMP    = 2'd2;

	// 2-bit hop status to availability code
	function automatic logic [AVAIL_W-1:0] hop_code(input logic [1:0] two);
		logic [AVAIL_W-1:0] r;
		case (two)
			2'd0:    r = AV_OK;
			2'd2:    r = AV_TEMP;
			default: r = AV_BLOCKED;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/vrte_req_if.sv =====
// Request channel interface of the route table engine.
interface vrte_req_if #(parameter int VID_BITS = vrte_pkg::VID_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic [vrte_pkg::KIND_W-1:0]   kind;
	logic [vrte_pkg::PATH_W-1:0]   path_id;
	logic [VID_BITS-1:0]           vid_a;
	logic [VID_BITS-1:0]           vid_b;
	logic [VID_BITS-1:0]           prev_hop;
	logic [VID_BITS-1:0]           next_hop;
	logic                          is_vset;
	logic [vrte_pkg::STATUS_W-1:0] status_in;
	logic                          hop_side;
	logic [1:0]                    hop_value;
	logic [vrte_pkg::RIDX_W-1:0]   route_index;

	modport source (output valid, kind, path_id, vid_a, vid_b, prev_hop, next_hop, is_vset,
		status_in, hop_side, hop_value, route_index, input ready);
	modport sink (input valid, kind, path_id, vid_a, vid_b, prev_hop, next_hop, is_vset,
		status_in, hop_side, hop_value, route_index, output ready);
endinterface

// ===== hw/rtl/vrte_rsp_if.sv =====
// Response channel interface of the route table engine.
interface vrte_rsp_if #(parameter int VID_BITS = vrte_pkg::VID_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic                          ok;
	logic [vrte_pkg::PATH_W-1:0]   path_out;
	logic [VID_BITS-1:0]           hop_out;
	logic [vrte_pkg::COUNT_W-1:0]  route_count;
	logic                          is_listed;
	logic                          is_only;
	logic [vrte_pkg::AVAIL_W-1:0]  availability;
	logic [vrte_pkg::STATUS_W-1:0] status_out;

	modport source (output valid, ok, path_out, hop_out, route_count, is_listed, is_only,
		availability, status_out, input ready);
	modport sink (input valid, ok, path_out, hop_out, route_count, is_listed, is_only,
		availability, status_out, output ready);
endinterface

// ===== hw/rtl/vrte_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vrte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/virtual_route_table_engine.sv =====
// Virtual route table engine: route table with scan-based lookup sequencer.
//
// Usage: one request channel (req) carries an operation item: kind, path id,
// endpoints and insert data. One response channel (rsp) returns exactly one
// result item per request. Both use valid/ready; an item moves when both high.
// Every request scans the whole table once through the single read port of
// the entry RAM, one entry per cycle. A pick of rank r repeats the scan once
// per rank (an ascending min-search). req.ready is high only while the
// sequencer is idle; one item is in work at a time. The result sits in an
// output register; if the receiver stalls, the sequencer holds its finished
// result until the register is free, and the table update is committed
// together with the result.
// Reset clears all entry valid bits (flip-flops), so the table is empty at
// once; entry payload lives in RAM and is never cleared. Clear scans the
// whole table like every other operation.
module virtual_route_table_engine #(
	parameter int ENTRIES  = vrte_pkg::ENTRIES_DEF,
	parameter int VID_BITS = vrte_pkg::VID_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	vrte_req_if.sink   req,
	vrte_rsp_if.source rsp
);
	import vrte_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	typedef struct packed {
		logic [PATH_W-1:0]   path;
		logic [VID_BITS-1:0] src;
		logic [VID_BITS-1:0] dst;
		logic [VID_BITS-1:0] prv;
		logic [VID_BITS-1:0] nxt;
		logic                vset;
		logic [STATUS_W-1:0] status;
		logic [1:0]          listed;
	} entry_t;

	localparam int EW = $bits(entry_t);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t state_q;

	// captured request
	kind_t               kind_q;
	logic [PATH_W-1:0]   pid_q;
	logic [VID_BITS-1:0] va_q, vb_q, ph_q, nh_q;
	logic                vs_q;
	logic [STATUS_W-1:0] stin_q;
	logic                side_q;
	logic [1:0]          hv_q;
	logic [RIDX_W-1:0]   ridx_q;

	// table valid bits
	logic [ENTRIES-1:0] valid_q;

	// scan control
	logic [CW-1:0] idx_q;
	logic          rv_s1;
	logic [IW-1:0] ri_s1;
	logic [RIDX_W-1:0] pass_q;

	// scan accumulators
	logic                hit_q;
	logic [IW-1:0]       k_q;
	entry_t              kd_q;
	logic                free_v_q;
	logic [IW-1:0]       free_idx_q;
	logic [CW-1:0]       cnt_q;
	logic                best_v_q;
	logic [PATH_W-1:0]   best_path_q;
	logic [VID_BITS-1:0] best_hop_q;
	logic                thr_v_q;
	logic [PATH_W-1:0]   thr_q;

	// output register
	logic                rsp_valid_q;
	logic                ok_q;
	logic [PATH_W-1:0]   path_out_q;
	logic [VID_BITS-1:0] hop_out_q;
	logic [COUNT_W-1:0]  count_q;
	logic                listed_q;
	logic                only_q;
	logic [AVAIL_W-1:0]  avail_q;
	logic [STATUS_W-1:0] status_q;

	// RAM port
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [EW-1:0] ram_rdata;
	entry_t        e_s1;

	logic rd_en, pass_end, fin_go, in_acc;

	assign in_acc   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rd_en    = (state_q == S_SCAN) && (32'(idx_q) < ENTRIES);
	assign pass_end = (state_q == S_SCAN) && !rd_en && !rv_s1;
	assign fin_go   = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);

	vrte_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	assign e_s1 = entry_t'(ram_rdata);

	// per-entry match terms for the entry coming out of the RAM
	logic e_vld, e_fa, e_ta, e_la, e_lb, e_hit, e_cand;
	always_comb begin
		e_vld = valid_q[ri_s1];
		e_fa  = (e_s1.src == va_q);
		e_ta  = (e_s1.dst == va_q);
		e_la  = e_vld && ((e_s1.listed[0] && e_fa) || (e_s1.listed[1] && e_ta));
		e_lb  = e_vld && ((e_s1.listed[0] && e_s1.src == vb_q) ||
			(e_s1.listed[1] && e_s1.dst == vb_q));
		e_hit = e_vld && (e_s1.path == pid_q);
		if (kind_q == K_PICK) begin
			e_cand = e_la && (!thr_v_q || (e_s1.path > thr_q));
		end else if (kind_q == K_VSET) begin
			e_cand = e_lb && e_s1.vset && (e_fa || e_ta);
		end else begin
			e_cand = 1'b0;
		end
	end

	// finish: result and table update from the scan summary
	logic                fm, tm, lak;
	logic                r_ok, r_listed, r_only;
	logic [PATH_W-1:0]   r_path;
	logic [VID_BITS-1:0] r_hop;
	logic [COUNT_W-1:0]  r_count;
	logic [AVAIL_W-1:0]  r_avail;
	logic [STATUS_W-1:0] r_status, s_new;
	logic                v_clr_all, v_set, v_clr;
	logic [IW-1:0]       v_idx;
	entry_t              ins_e, mod_e;

	always_comb begin
		fm        = (kd_q.src == va_q);
		tm        = (kd_q.dst == va_q);
		lak       = (kd_q.listed[0] && fm) || (kd_q.listed[1] && tm);
		r_ok      = 1'b0;
		r_listed  = 1'b0;
		r_only    = 1'b0;
		r_path    = '0;
		r_hop     = '0;
		r_count   = '0;
		r_avail   = AV_BLOCKED;
		r_status  = '0;
		s_new     = kd_q.status;
		v_clr_all = 1'b0;
		v_set     = 1'b0;
		v_clr     = 1'b0;
		v_idx     = k_q;
		ram_we    = 1'b0;
		ram_waddr = k_q;
		mod_e     = kd_q;
		ins_e.path   = pid_q;
		ins_e.src    = va_q;
		ins_e.dst    = vb_q;
		ins_e.prv    = ph_q;
		ins_e.nxt    = nh_q;
		ins_e.vset   = vs_q;
		ins_e.status = stin_q;
		ins_e.listed = 2'b11;
		ram_wdata = kd_q;
		case (kind_q)
			K_CLEAR: begin
				r_ok      = 1'b1;
				v_clr_all = 1'b1;
			end
			K_INSERT: begin
				if (!hit_q && free_v_q) begin
					r_ok      = 1'b1;
					v_set     = 1'b1;
					v_idx     = free_idx_q;
					ram_we    = 1'b1;
					ram_waddr = free_idx_q;
					ram_wdata = ins_e;
				end
			end
			K_REMOVE: begin
				if (hit_q) begin
					r_ok  = 1'b1;
					v_clr = 1'b1;
				end
			end
			K_DROP_END: begin
				if (hit_q && lak) begin
					r_ok = 1'b1;
					if (fm) mod_e.listed[0] = 1'b0;
					if (tm) mod_e.listed[1] = 1'b0;
					ram_we    = 1'b1;
					ram_wdata = mod_e;
				end
			end
			K_ADD_END: begin
				if (hit_q && (fm || tm)) begin
					r_ok = 1'b1;
					if (fm) mod_e.listed[0] = 1'b1;
					if (tm) mod_e.listed[1] = 1'b1;
					ram_we    = 1'b1;
					ram_wdata = mod_e;
				end
			end
			K_QUERY_END: begin
				r_listed = hit_q && lak;
				r_only   = r_listed && (32'(cnt_q) == 1);
				r_ok     = r_listed;
				r_count  = (32'(cnt_q) > 127) ? 7'd127 : COUNT_W'(cnt_q);
			end
			K_PICK: begin
				if (best_v_q) begin
					r_ok   = 1'b1;
					r_path = best_path_q;
					r_hop  = best_hop_q;
				end
			end
			K_HOP: begin
				if (hit_q) begin
					r_ok     = 1'b1;
					r_status = kd_q.status;
					if (fm) r_hop = kd_q.prv;
					else if (tm) r_hop = kd_q.nxt;
					if (kd_q.status == 7'd0 || kd_q.status == 7'd16) r_avail = AV_OK;
					else if (fm) r_avail = hop_code(kd_q.status[3:2]);
					else if (tm) r_avail = hop_code(kd_q.status[1:0]);
				end
			end
			K_VSET: begin
				if (best_v_q) begin
					r_ok   = 1'b1;
					r_path = best_path_q;
				end
			end
			K_SET_HOP: begin
				if (hit_q) begin
					if (side_q) s_new[3:2] = hv_q;
					else s_new[1:0] = hv_q;
					r_ok         = 1'b1;
					r_status     = s_new;
					mod_e.status = s_new;
					ram_we       = 1'b1;
					ram_wdata    = mod_e;
				end
			end
			K_DISMANTLE: begin
				if (hit_q) begin
					if (side_q) s_new[6] = (hv_q != 2'd0);
					else s_new[5] = (hv_q != 2'd0);
					r_ok         = 1'b1;
					r_status     = s_new;
					mod_e.status = s_new;
					ram_we       = 1'b1;
					ram_wdata    = mod_e;
				end
			end
			default: begin
			end
		endcase
		ram_we = ram_we && fin_go;
	end

	// sequencer and scan accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= '0;
			idx_q    <= '0;
			rv_s1    <= 1'b0;
			pass_q   <= '0;
			hit_q    <= 1'b0;
			free_v_q <= 1'b0;
			cnt_q    <= '0;
			best_v_q <= 1'b0;
			thr_v_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rv_s1 <= rd_en;
			if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
			// output register: load on commit, drop when taken
			if (fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q  <= S_SCAN;
						idx_q    <= '0;
						pass_q   <= '0;
						hit_q    <= 1'b0;
						free_v_q <= 1'b0;
						cnt_q    <= '0;
						best_v_q <= 1'b0;
						thr_v_q  <= 1'b0;
					end
				end
				S_SCAN: begin
					if (rv_s1) begin
						if (e_hit) begin
							hit_q <= 1'b1;
						end
						if (!e_vld && !free_v_q) begin
							free_v_q <= 1'b1;
						end
						if (e_la) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (e_cand && (!best_v_q || (e_s1.path < best_path_q))) begin
							best_v_q <= 1'b1;
						end
					end
					if (pass_end) begin
						if (kind_q == K_PICK && best_v_q && pass_q != ridx_q) begin
							// next rank: search above the current minimum
							thr_v_q  <= 1'b1;
							pass_q   <= pass_q + 1'b1;
							best_v_q <= 1'b0;
							hit_q    <= 1'b0;
							free_v_q <= 1'b0;
							cnt_q    <= '0;
							idx_q    <= '0;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q     <= S_IDLE;
						if (v_clr_all) valid_q <= '0;
						else if (v_set) valid_q[v_idx] <= 1'b1;
						else if (v_clr) valid_q[v_idx] <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= kind_t'(req.kind);
			pid_q  <= req.path_id;
			va_q   <= req.vid_a;
			vb_q   <= req.vid_b;
			ph_q   <= req.prev_hop;
			nh_q   <= req.next_hop;
			vs_q   <= req.is_vset;
			stin_q <= req.status_in;
			side_q <= req.hop_side;
			hv_q   <= req.hop_value;
			ridx_q <= req.route_index;
		end
		if (rd_en) begin
			ri_s1 <= idx_q[IW-1:0];
		end
		if (state_q == S_SCAN && rv_s1) begin
			if (e_hit) begin
				k_q  <= ri_s1;
				kd_q <= e_s1;
			end
			if (!e_vld && !free_v_q) begin
				free_idx_q <= ri_s1;
			end
			if (e_cand && (!best_v_q || (e_s1.path < best_path_q))) begin
				best_path_q <= e_s1.path;
				best_hop_q  <= e_fa ? e_s1.prv : e_s1.nxt;
			end
		end
		if (pass_end && kind_q == K_PICK) begin
			thr_q <= best_path_q;
		end
		if (fin_go) begin
			ok_q       <= r_ok;
			path_out_q <= r_path;
			hop_out_q  <= r_hop;
			count_q    <= r_count;
			listed_q   <= r_listed;
			only_q     <= r_only;
			avail_q    <= r_avail;
			status_q   <= r_status;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.ok           = ok_q;
	assign rsp.path_out     = path_out_q;
	assign rsp.hop_out      = hop_out_q;
	assign rsp.route_count  = count_q;
	assign rsp.is_listed    = listed_q;
	assign rsp.is_only      = only_q;
	assign rsp.availability = avail_q;
	assign rsp.status_out   = status_q;

	// scan index never exceeds the table size
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(idx_q) <= ENTRIES)
		else $error("scan index out of range");

	// a clear leaves the table empty
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && kind_q == K_CLEAR) |=> (valid_q == '0))
		else $error("table not empty after clear");

	// a successful insert adds exactly one entry
	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && kind_q == K_INSERT && r_ok) |=>
		($countones(valid_q) == $past($countones(valid_q)) + 1))
		else $error("insert did not add one entry");

	// the table changes only when an operation commits
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fin_go |=> $stable(valid_q))
		else $error("valid bits changed outside commit");
endmodule

// ===== tb/sv/virtual_route_table_engine_tb.sv =====
// Self-checking testbench for the virtual route table engine.
`timescale 1ns / 100ps

module virtual_route_table_engine_tb;
	import vrte_pkg::*;

	localparam int N      = ENTRIES_DEF;
	localparam int VW     = VID_BITS_DEF;
	localparam int STALL  = 20000;

	// a kind code outside the defined operations
	localparam logic [KIND_W-1:0] KIND_BAD = 4'd15;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [PATH_W-1:0]   path_id;
		logic [VW-1:0]       vid_a;
		logic [VW-1:0]       vid_b;
		logic [VW-1:0]       prev_hop;
		logic [VW-1:0]       next_hop;
		logic                is_vset;
		logic [STATUS_W-1:0] status_in;
		logic                hop_side;
		logic [1:0]          hop_value;
		logic [RIDX_W-1:0]   route_index;
	} op_t;

	typedef struct packed {
		logic                ok;
		logic [PATH_W-1:0]   path_out;
		logic [VW-1:0]       hop_out;
		logic [COUNT_W-1:0]  route_count;
		logic                is_listed;
		logic                is_only;
		logic [AVAIL_W-1:0]  availability;
		logic [STATUS_W-1:0] status_out;
	} reply_t;

	// Shadow copy of the route table; predicts each reply and checks it
	class route_table_shadow;
		bit                  used [N];
		logic [PATH_W-1:0]   path [N];
		logic [VW-1:0]       from_vid [N], to_vid [N], prev_h [N], next_h [N];
		bit                  vset [N];
		logic [STATUS_W-1:0] status [N];
		logic [1:0]          listed [N];
		reply_t              pending_replies[$];
		int                  failures;

		function int find(logic [PATH_W-1:0] p);
			for (int i = 0; i < N; i++)
				if (used[i] && path[i] == p) return i;
			return -1;
		endfunction

		function bit listed_at(int i, logic [VW-1:0] v);
			return used[i] && ((listed[i][0] && from_vid[i] == v) ||
				(listed[i][1] && to_vid[i] == v));
		endfunction

		function logic [AVAIL_W-1:0] avail_of(logic [1:0] two);
			if (two == 2'd0) return AV_OK;
			if (two == 2'd2) return AV_TEMP;
			return AV_BLOCKED;
		endfunction

		function void note_request(op_t o);
			reply_t r;
			int k, n, rk, best;
			bit lst;
			r = '0;
			k = find(o.path_id);
			case (o.kind)
				K_CLEAR: begin
					foreach (used[i]) used[i] = 0;
					r.ok = 1;
				end
				K_INSERT: if (k < 0) begin
					for (int i = 0; i < N; i++) if (!used[i]) begin
						used[i] = 1; path[i] = o.path_id;
						from_vid[i] = o.vid_a; to_vid[i] = o.vid_b;
						prev_h[i] = o.prev_hop; next_h[i] = o.next_hop;
						vset[i] = o.is_vset; status[i] = o.status_in;
						listed[i] = 2'b11; r.ok = 1;
						break;
					end
				end
				K_REMOVE: if (k >= 0) begin
					used[k] = 0; listed[k] = 0; r.ok = 1;
				end
				K_DROP_END: if (k >= 0 && listed_at(k, o.vid_a)) begin
					if (from_vid[k] == o.vid_a) listed[k][0] = 0;
					if (to_vid[k] == o.vid_a) listed[k][1] = 0;
					r.ok = 1;
				end
				K_ADD_END: if (k >= 0 && (from_vid[k] == o.vid_a || to_vid[k] == o.vid_a)) begin
					if (from_vid[k] == o.vid_a) listed[k][0] = 1;
					if (to_vid[k] == o.vid_a) listed[k][1] = 1;
					r.ok = 1;
				end
				K_QUERY_END: begin
					n = 0;
					for (int i = 0; i < N; i++) if (listed_at(i, o.vid_a)) n++;
					lst = (k >= 0) && listed_at(k, o.vid_a);
					r.route_count = (n > 127) ? 7'd127 : n[COUNT_W-1:0];
					r.is_listed = lst;
					r.is_only = lst && n == 1;
					r.ok = lst;
				end
				K_PICK: for (int i = 0; i < N; i++) if (listed_at(i, o.vid_a)) begin
					rk = 0;
					for (int j = 0; j < N; j++)
						if (listed_at(j, o.vid_a) && path[j] < path[i]) rk++;
					if (rk == o.route_index) begin
						r.ok = 1; r.path_out = path[i];
						r.hop_out = (from_vid[i] == o.vid_a) ? prev_h[i] : next_h[i];
						break;
					end
				end
				K_HOP: if (k >= 0) begin
					r.ok = 1; r.status_out = status[k];
					if (from_vid[k] == o.vid_a) r.hop_out = prev_h[k];
					else if (to_vid[k] == o.vid_a) r.hop_out = next_h[k];
					if (status[k] == 0 || status[k] == 16) r.availability = AV_OK;
					else if (from_vid[k] == o.vid_a) r.availability = avail_of(status[k][3:2]);
					else if (to_vid[k] == o.vid_a) r.availability = avail_of(status[k][1:0]);
				end
				K_VSET: begin
					best = -1;
					for (int i = 0; i < N; i++)
						if (listed_at(i, o.vid_b) && vset[i] &&
							(from_vid[i] == o.vid_a || to_vid[i] == o.vid_a))
							if (best < 0 || path[i] < path[best]) best = i;
					if (best >= 0) begin
						r.ok = 1; r.path_out = path[best];
					end
				end
				K_SET_HOP: if (k >= 0) begin
					if (o.hop_side) status[k][3:2] = o.hop_value;
					else status[k][1:0] = o.hop_value;
					r.ok = 1; r.status_out = status[k];
				end
				K_DISMANTLE: if (k >= 0) begin
					if (o.hop_side) status[k][6] = (o.hop_value != 0);
					else status[k][5] = (o.hop_value != 0);
					r.ok = 1; r.status_out = status[k];
				end
				default: ;
			endcase
			pending_replies.push_back(r);
		endfunction

		function void check_reply(reply_t a);
			reply_t e;
			if (pending_replies.size() == 0) begin
				$error("reply with none expected");
				failures++;
				return;
			end
			e = pending_replies.pop_front();
			if (a.ok !== e.ok) begin
				$error("ok: expected %0h actual %0h", e.ok, a.ok); failures++;
			end
			if (a.path_out !== e.path_out) begin
				$error("path_out: expected %0h actual %0h", e.path_out, a.path_out); failures++;
			end
			if (a.hop_out !== e.hop_out) begin
				$error("hop_out: expected %0h actual %0h", e.hop_out, a.hop_out); failures++;
			end
			if (a.route_count !== e.route_count) begin
				$error("route_count: expected %0d actual %0d", e.route_count, a.route_count);
				failures++;
			end
			if (a.is_listed !== e.is_listed) begin
				$error("is_listed: expected %0h actual %0h", e.is_listed, a.is_listed); failures++;
			end
			if (a.is_only !== e.is_only) begin
				$error("is_only: expected %0h actual %0h", e.is_only, a.is_only); failures++;
			end
			if (a.availability !== e.availability) begin
				$error("availability: expected %0h actual %0h", e.availability, a.availability);
				failures++;
			end
			if (a.status_out !== e.status_out) begin
				$error("status_out: expected %0h actual %0h", e.status_out, a.status_out);
				failures++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	bit quiet = 0;
	int idle_cycles = 0;
	route_table_shadow table_shadow = new();
	logic [VW-1:0] vid_pool [8];
	logic [PATH_W-1:0] path_pool [24];

	vrte_req_if req ();
	vrte_rsp_if rsp ();

	virtual_route_table_engine uut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always #1 clk = ~clk;

	// Reply side: random stall bursts, checking, watchdog
	always @(posedge clk) begin
		static int stall_left = 0;
		if (rsp.valid && rsp.ready) begin
			table_shadow.check_reply({rsp.ok, rsp.path_out, rsp.hop_out, rsp.route_count,
				rsp.is_listed, rsp.is_only, rsp.availability, rsp.status_out});
		end
		if (!arst_n) rsp.ready <= 0;
		else if (stall_left > 0) begin
			stall_left--;
			rsp.ready <= 0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 7);
			rsp.ready <= 0;
		end else rsp.ready <= 1;
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Present one item and hold it until accepted; valid may then drop for a random idle gap
	task automatic send_op(op_t o);
		req.valid <= 1;
		{req.kind, req.path_id, req.vid_a, req.vid_b, req.prev_hop, req.next_hop,
			req.is_vset, req.status_in, req.hop_side, req.hop_value, req.route_index} <= o;
		do @(posedge clk); while (!req.ready);
		table_shadow.note_request(o);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req.valid <= 0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	function automatic op_t make_op(logic [KIND_W-1:0] kind, logic [PATH_W-1:0] p,
		logic [VW-1:0] a, logic [VW-1:0] b);
		op_t o;
		logic [127:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom};
		o = rnd[$bits(op_t)-1:0];
		o.kind = kind; o.path_id = p; o.vid_a = a; o.vid_b = b;
		o.route_index = 0;
		return o;
	endfunction

	// Random item biased toward the pool so that hits and duplicates occur
	function automatic op_t random_op();
		op_t o;
		int w;
		logic [KIND_W-1:0] kind;
		w = $urandom_range(0, 99);
		if (w < 1) kind = K_CLEAR;
		else if (w < 2) kind = KIND_W'($urandom_range(11, 15));
		else if (w < 27) kind = K_INSERT;
		else if (w < 35) kind = K_REMOVE;
		else if (w < 43) kind = K_DROP_END;
		else if (w < 51) kind = K_ADD_END;
		else if (w < 61) kind = K_QUERY_END;
		else if (w < 71) kind = K_PICK;
		else if (w < 81) kind = K_HOP;
		else if (w < 89) kind = K_VSET;
		else if (w < 95) kind = K_SET_HOP;
		else kind = K_DISMANTLE;
		o = make_op(kind, ($urandom_range(0, 9) == 0) ? $urandom : path_pool[$urandom_range(0, 23)],
			vid_pool[$urandom_range(0, 7)], vid_pool[$urandom_range(0, 7)]);
		w = $urandom_range(0, 99);
		o.route_index = (w < 90) ? RIDX_W'($urandom_range(0, 3)) :
			(w < 97) ? RIDX_W'($urandom_range(0, 15)) : RIDX_W'($urandom_range(0, 63));
		return o;
	endfunction

	initial begin
		op_t o;
		req.valid = 0; req.kind = '0; req.path_id = '0; req.vid_a = '0; req.vid_b = '0;
		req.prev_hop = '0; req.next_hop = '0; req.is_vset = 0; req.status_in = '0;
		req.hop_side = 0; req.hop_value = '0; req.route_index = '0; rsp.ready = 0;
		vid_pool[0] = '0; vid_pool[1] = '1;
		for (int i = 2; i < 8; i++) vid_pool[i] = VW'($urandom);
		path_pool[0] = '0; path_pool[1] = '1;
		for (int i = 2; i < 24; i++) path_pool[i] = $urandom;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, each operation, the documented corner cases
		send_op(make_op(K_CLEAR, 0, 0, 0));
		o = make_op(K_INSERT, '1, '1, 0); o.prev_hop = '1; o.next_hop = '1;
		o.is_vset = 1; o.status_in = '1; send_op(o);
		o = make_op(K_INSERT, 0, 5, '1); o.prev_hop = 0; o.next_hop = 0;
		o.is_vset = 1; o.status_in = 0; send_op(o);
		o = make_op(K_INSERT, 7, 5, 5); o.status_in = 16; send_op(o);  // both ends same node
		send_op(make_op(K_INSERT, 0, 1, 2));                            // duplicate
		send_op(make_op(K_QUERY_END, 0, 5, 0));
		send_op(make_op(K_QUERY_END, '1, '1, 0));
		o = make_op(K_PICK, 0, 5, 0); send_op(o);
		o.route_index = 1; send_op(o);
		o.route_index = 2; send_op(o);                                  // rank out of range
		o = make_op(K_PICK, 0, 9, 0); o.route_index = '1; send_op(o);   // no route there
		send_op(make_op(K_HOP, 0, 5, 0));
		send_op(make_op(K_HOP, 7, 5, 0));
		send_op(make_op(K_HOP, '1, '1, 0));
		send_op(make_op(K_HOP, '1, 3, 0));                              // neither end
		send_op(make_op(K_VSET, 0, 5, '1));
		send_op(make_op(K_VSET, 0, 6, '1));                             // none found
		o = make_op(K_SET_HOP, '1, 0, 0); o.hop_side = 1; o.hop_value = 2; send_op(o);
		o.hop_side = 0; o.hop_value = 3; send_op(o);
		send_op(make_op(K_HOP, '1, '1, 0));
		o = make_op(K_DISMANTLE, 0, 0, 0); o.hop_side = 1; o.hop_value = 1; send_op(o);
		o.hop_side = 0; o.hop_value = 0; o.path_id = 99; send_op(o);    // missing path
		send_op(make_op(K_DROP_END, 0, 5, 0));
		send_op(make_op(K_DROP_END, 0, 5, 0));                          // already dropped
		send_op(make_op(K_ADD_END, 0, 4, 0));                           // foreign endpoint
		send_op(make_op(K_ADD_END, 0, 5, 0));
		send_op(make_op(K_REMOVE, 7, 0, 0));
		send_op(make_op(K_REMOVE, 7, 0, 0));
		send_op(make_op(KIND_BAD, 0, 0, 0));

		// Fill the table at one endpoint, overflow it, walk the deepest rank
		send_op(make_op(K_CLEAR, 0, 0, 0));
		for (int i = 0; i < N + 1; i++) send_op(make_op(K_INSERT, $urandom, 3, VW'($urandom)));
		send_op(make_op(K_QUERY_END, 0, 3, 0));
		o = make_op(K_PICK, 0, 3, 0); o.route_index = RIDX_W'(N - 1); send_op(o);
		send_op(make_op(K_CLEAR, 0, 0, 0));

		// Random traffic; the tail runs without idling
		for (int i = 0; i < 1830; i++) begin
			if (i == 1650) quiet = 1;
			send_op(random_op());
		end
		req.valid <= 0;

		while (table_shadow.pending_replies.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (table_shadow.failures == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/vrte_pkg.sv
hw/rtl/vrte_req_if.sv
hw/rtl/vrte_rsp_if.sv
hw/rtl/vrte_ram.sv
hw/rtl/virtual_route_table_engine.sv
tb/sv/virtual_route_table_engine_tb.sv
